// File: src/pse_pkg.sv
// ----------------------------------------------------------------------------
// pse_pkg
// Shared types and constants for the postfix stack evaluator: character
// codes, status codes, arithmetic unit operations and request/response types.
// ----------------------------------------------------------------------------
`default_nettype none

package pse_pkg;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_CARET = 8'h5E;

	localparam logic [4:0] DIV_LAST = 5'd31;
	localparam logic [4:0] POW_LAST = 5'd30;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_UNDERFLOW = 3'd1,
		ST_OVERFLOW  = 3'd2,
		ST_DIVZERO   = 3'd3,
		ST_EMPTY     = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		OP_ADD  = 3'd0,
		OP_SUB  = 3'd1,
		OP_MUL  = 3'd2,
		OP_DIV  = 3'd3,
		OP_POW  = 3'd4,
		OP_ZERO = 3'd5
	} alu_op_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] result;
	} alu_rsp_t;

	function automatic alu_op_t decode_op(input logic [7:0] sym);
		alu_op_t op;
		case (sym)
			CH_PLUS:  op = OP_ADD;
			CH_MINUS: op = OP_SUB;
			CH_STAR:  op = OP_MUL;
			CH_SLASH: op = OP_DIV;
			CH_CARET: op = OP_POW;
			default:  op = OP_ZERO;
		endcase
		return op;
	endfunction

endpackage

`default_nettype wire

// File: src/postfix_stack_evaluator_top.sv
// ----------------------------------------------------------------------------
// postfix_stack_evaluator_top
// Postfix expression evaluator: digits push, operators pop two and push one,
// a NUL character emits the top of stack with a status and clears the stack.
//
// Channel   Direction  Handshake                     Payload
// symbol    in         symbol_valid / symbol_ready   symbol[7:0]
// result    out        result_valid / result_ready   value[31:0], status[2:0]
//
// A digit or an ignored character is handled in S_IDLE; NUL also passes through
// S_END and waits on result_ready. An operator, + - * or an unknown code, reads
// both operands and runs in S_EXEC; / uses a restoring divider and ^ one multiplier
// shared by the square and multiply steps. The stack RAM port sets the extra reads.
// No clearing pass after reset: only the count and status are reset.
// ----------------------------------------------------------------------------
`default_nettype none

module postfix_stack_evaluator_top #(
	parameter int STACK_DEPTH = 16
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          symbol_valid,
	output logic         symbol_ready,
	input  wire   [7:0]  symbol,
	output logic         result_valid,
	input  wire          result_ready,
	output logic signed [31:0] value,
	output logic  [2:0]  status
);
	import pse_pkg::*;

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_RDR  = 5'b00010,
		S_RDL  = 5'b00100,
		S_EXEC = 5'b01000,
		S_END  = 5'b10000
	} state_t;

	state_t      state_q;
	logic [CW-1:0] count_q;
	status_t     sticky_q;
	alu_op_t     op_q;
	logic [31:0] right_q;
	logic        res_valid_q;
	logic [31:0] value_q;
	status_t     status_q;

	logic          accept;
	logic          is_digit;
	logic          is_full;
	logic [7:0]    digit_off;
	logic [CW-1:0] cnt_m1;
	logic [CW-1:0] cnt_m2;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [31:0]   wr_data;
	logic [AW-1:0] rd_addr;
	logic [31:0]   rd_data;
	logic          out_load;
	alu_req_t      alu_req;
	alu_rsp_t      alu_rsp;

	assign symbol_ready = (state_q == S_IDLE);
	assign accept       = symbol_valid && symbol_ready;
	assign is_digit     = (symbol >= CH_ZERO) && (symbol <= CH_NINE);
	assign is_full      = (count_q == CW'(STACK_DEPTH));
	assign digit_off    = symbol - CH_ZERO;
	assign cnt_m1       = count_q - CW'(1);
	assign cnt_m2       = count_q - CW'(2);

	assign rd_addr = (state_q == S_RDR) ? cnt_m2[AW-1:0] : cnt_m1[AW-1:0];

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = count_q[AW-1:0];
		wr_data = {28'd0, digit_off[3:0]};
		if (state_q == S_EXEC) begin
			wr_en   = alu_rsp.done;
			wr_addr = cnt_m2[AW-1:0];
			wr_data = alu_rsp.result;
		end else if (accept && symbol != CH_NUL && sticky_q == ST_OK && is_digit && !is_full) begin
			wr_en = 1'b1;
		end
	end

	assign alu_req.start = (state_q == S_RDL) && !(op_q == OP_DIV && right_q == 32'd0);
	assign alu_req.op    = op_q;

	assign out_load = (state_q == S_END) && (!res_valid_q || result_ready);

	pse_stack #(
		.DEPTH (STACK_DEPTH),
		.AW    (AW)
	) u_stack (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	pse_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.a      (rd_data),
		.b      (right_q),
		.rsp    (alu_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			sticky_q    <= ST_OK;
			res_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (symbol == CH_NUL) begin
							state_q <= S_END;
						end else if (sticky_q != ST_OK) begin
							state_q <= S_IDLE;
						end else if (is_digit) begin
							if (is_full) begin
								sticky_q <= ST_OVERFLOW;
							end else begin
								count_q <= count_q + CW'(1);
							end
						end else if (count_q < CW'(2)) begin
							sticky_q <= ST_UNDERFLOW;
						end else begin
							state_q <= S_RDR;
						end
					end
				end
				S_RDR: state_q <= S_RDL;
				S_RDL: begin
					if (alu_req.start) begin
						state_q <= S_EXEC;
					end else begin
						sticky_q <= ST_DIVZERO;
						state_q  <= S_IDLE;
					end
				end
				S_EXEC: begin
					if (alu_rsp.done) begin
						count_q <= cnt_m1;
						state_q <= S_IDLE;
					end
				end
				S_END: begin
					if (out_load) begin
						count_q  <= '0;
						sticky_q <= ST_OK;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= decode_op(symbol);
		end
		if (state_q == S_RDR) begin
			right_q <= rd_data;
		end
		if (out_load) begin
			if (sticky_q != ST_OK) begin
				value_q  <= 32'd0;
				status_q <= sticky_q;
			end else if (count_q == '0) begin
				value_q  <= 32'd0;
				status_q <= ST_EMPTY;
			end else begin
				value_q  <= rd_data;
				status_q <= ST_OK;
			end
		end
	end

	assign result_valid = res_valid_q;
	assign value        = value_q;
	assign status       = status_q;

`ifndef SYNTHESIS
	a_err_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && status != ST_OK) |-> (value == 32'sd0))
		else $error("nonzero value with error status");

	a_op_reads: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && symbol != CH_NUL && sticky_q == ST_OK && !is_digit
		 && count_q >= CW'(2)) |=> (state_q == S_RDR))
		else $error("operator did not start operand reads");

	a_alu_done_exec: assert property (@(posedge clk) disable iff (!arst_n)
		alu_rsp.done |-> (state_q == S_EXEC))
		else $error("arithmetic unit finished outside execute");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> (count_q <= CW'(STACK_DEPTH)))
		else $error("stack count beyond depth");
`endif

endmodule

`default_nettype wire

// File: src/pse_alu.sv
// ----------------------------------------------------------------------------
// pse_alu
// Shared arithmetic unit: add, subtract and multiply, restoring
// division over 32 steps and square-and-multiply power on one multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module pse_alu (
	input  wire                clk,
	input  wire                arst_n,
	input  pse_pkg::alu_req_t  req,
	input  wire         [31:0] a,
	input  wire         [31:0] b,
	output pse_pkg::alu_rsp_t  rsp
);
	import pse_pkg::*;

	typedef enum logic [4:0] {
		A_IDLE = 5'b00001,
		A_DIV  = 5'b00010,
		A_POWM = 5'b00100,
		A_POWS = 5'b01000,
		A_DONE = 5'b10000
	} alu_state_t;

	alu_state_t  state_q;
	logic [31:0] acc_q;
	logic [31:0] sq_q;
	logic [31:0] rem_q;
	logic [31:0] arg_q;
	logic [4:0]  cnt_q;
	logic        neg_q;

	logic [31:0] mul_x;
	logic [31:0] mul_y;
	logic [31:0] mul_p;
	logic [31:0] shifted;
	logic [32:0] trial;
	logic        take;
	logic [31:0] mag_a;
	logic [31:0] mag_b;

	assign mul_x = (state_q == A_IDLE) ? a : ((state_q == A_POWM) ? acc_q : sq_q);
	assign mul_y = (state_q == A_IDLE) ? b : sq_q;
	assign mul_p = mul_x * mul_y;

	assign shifted = {rem_q[30:0], acc_q[31]};
	assign trial   = {1'b0, shifted} - {1'b0, arg_q};
	assign take    = ~trial[32];

	assign mag_a = a[31] ? (32'd0 - a) : a;
	assign mag_b = b[31] ? (32'd0 - b) : b;

	assign rsp.done   = (state_q == A_DONE);
	assign rsp.result = neg_q ? (32'd0 - acc_q) : acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
		end else begin
			case (state_q)
				A_IDLE: begin
					if (req.start) begin
						if (req.op == OP_DIV) begin
							state_q <= A_DIV;
						end else if (req.op == OP_POW && !b[31]) begin
							state_q <= A_POWM;
						end else begin
							state_q <= A_DONE;
						end
					end
				end
				A_DIV: begin
					if (cnt_q == 5'd0) begin
						state_q <= A_DONE;
					end
				end
				A_POWM: state_q <= A_POWS;
				A_POWS: begin
					state_q <= (cnt_q == POW_LAST) ? A_DONE : A_POWM;
				end
				A_DONE:  state_q <= A_IDLE;
				default: state_q <= A_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			A_IDLE: begin
				if (req.start) begin
					neg_q <= 1'b0;
					case (req.op)
						OP_ADD: acc_q <= a + b;
						OP_SUB: acc_q <= a - b;
						OP_MUL: acc_q <= mul_p;
						OP_DIV: begin
							acc_q <= mag_a;
							rem_q <= 32'd0;
							arg_q <= mag_b;
							cnt_q <= DIV_LAST;
							neg_q <= a[31] ^ b[31];
						end
						OP_POW: begin
							if (b[31]) begin
								if (a == 32'd1) begin
									acc_q <= 32'd1;
								end else if (a == 32'hFFFF_FFFF) begin
									acc_q <= b[0] ? 32'hFFFF_FFFF : 32'd1;
								end else begin
									acc_q <= 32'd0;
								end
							end else begin
								acc_q <= 32'd1;
								sq_q  <= a;
								arg_q <= b;
								cnt_q <= 5'd0;
							end
						end
						default: acc_q <= 32'd0;
					endcase
				end
			end
			A_DIV: begin
				rem_q <= take ? trial[31:0] : shifted;
				acc_q <= {acc_q[30:0], take};
				cnt_q <= cnt_q - 5'd1;
			end
			A_POWM: begin
				if (arg_q[0]) begin
					acc_q <= mul_p;
				end
			end
			A_POWS: begin
				sq_q  <= mul_p;
				arg_q <= {1'b0, arg_q[31:1]};
				cnt_q <= cnt_q + 5'd1;
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

// File: src/pse_stack.sv
// ----------------------------------------------------------------------------
// pse_stack
// Operand stack storage: one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module pse_stack #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  wire           clk,
	input  wire           wr_en,
	input  wire  [AW-1:0] wr_addr,
	input  wire  [31:0]   wr_data,
	input  wire  [AW-1:0] rd_addr,
	output logic [31:0]   rd_data
);

	logic [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

`default_nettype wire

// File: sim/tb_postfix_stack_evaluator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_postfix_stack_evaluator_top
// Feeds postfix character streams into the evaluator and checks each emitted
// value and status against an in-bench evaluator. The stimulus is a short
// directed set, then random well-formed expressions mixed with overflow,
// sign-extreme, negative-exponent, error and noise streams. Both channels
// idle at random, and the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------

module tb_postfix_stack_evaluator_top;

	import pse_pkg::*;

	localparam int STACK_DEPTH = 16;
	localparam int LONG_HOLD   = 600;

	typedef struct {
		logic [31:0] value;
		status_t     status;
	} outcome_t;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_CHOPPY,
		RX_SPARSE
	} rx_mode_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               symbol_valid = 1'b0;
	logic               symbol_ready;
	logic [7:0]         symbol = 8'h00;
	logic               result_valid;
	logic               result_ready = 1'b0;
	logic signed [31:0] value;
	logic [2:0]         status;

	logic [7:0]  char_queue[$];
	outcome_t    outcomes[$];
	outcome_t    head_outcome;

	logic [31:0] eval_stack[STACK_DEPTH];
	int          eval_depth = 0;
	status_t     eval_status = ST_OK;

	int          total_chars = 0;
	int          accepted_chars = 0;
	int          results_seen = 0;
	int          mismatches = 0;

	int          burst_left = 0;
	int          gap_left = 0;
	rx_mode_t    rx_mode = RX_OPEN;
	int          mode_left = 0;
	int          hold_left = 0;
	logic        hold_done = 1'b0;

	postfix_stack_evaluator_top #(
		.STACK_DEPTH(STACK_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.symbol_valid(symbol_valid),
		.symbol_ready(symbol_ready),
		.symbol(symbol),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.value(value),
		.status(status)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [31:0] trunc_quotient(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] ma;
		logic [31:0] mb;
		logic [31:0] q;
		ma = a[31] ? -a : a;
		mb = b[31] ? -b : b;
		q = ma / mb;
		return (a[31] ^ b[31]) ? -q : q;
	endfunction

	function automatic logic [31:0] wrapped_power(input logic [31:0] base, input logic [31:0] ex);
		logic [31:0] acc;
		logic [31:0] sq;
		int i;
		acc = 32'd1;
		sq = base;
		if (ex[31]) begin
			if (base == 32'd1)
				return 32'd1;
			if (base == 32'hFFFF_FFFF)
				return ex[0] ? 32'hFFFF_FFFF : 32'd1;
			return 32'd0;
		end
		for (i = 0; i < 31; i++) begin
			if (ex[i])
				acc = acc * sq;
			sq = sq * sq;
		end
		return acc;
	endfunction

	task automatic evaluate_symbol(input logic [7:0] sym);
		outcome_t    done_expr;
		logic [31:0] lhs;
		logic [31:0] rhs;
		logic [31:0] res;
		if (sym == CH_NUL) begin
			done_expr.value = 32'd0;
			done_expr.status = eval_status;
			if (eval_status == ST_OK) begin
				if (eval_depth == 0)
					done_expr.status = ST_EMPTY;
				else
					done_expr.value = eval_stack[eval_depth - 1];
			end
			outcomes.push_back(done_expr);
			eval_depth = 0;
			eval_status = ST_OK;
		end else if (eval_status == ST_OK) begin
			if (sym >= CH_ZERO && sym <= CH_NINE) begin
				if (eval_depth >= STACK_DEPTH) begin
					eval_status = ST_OVERFLOW;
				end else begin
					eval_stack[eval_depth] = {24'd0, sym - CH_ZERO};
					eval_depth++;
				end
			end else if (eval_depth < 2) begin
				eval_status = ST_UNDERFLOW;
			end else begin
				rhs = eval_stack[eval_depth - 1];
				lhs = eval_stack[eval_depth - 2];
				res = 32'd0;
				case (sym)
					CH_PLUS:  res = lhs + rhs;
					CH_MINUS: res = lhs - rhs;
					CH_STAR:  res = lhs * rhs;
					CH_SLASH: begin
						if (rhs == 32'd0)
							eval_status = ST_DIVZERO;
						else
							res = trunc_quotient(lhs, rhs);
					end
					CH_CARET: res = wrapped_power(lhs, rhs);
					default:  res = 32'd0;
				endcase
				if (eval_status == ST_OK) begin
					eval_stack[eval_depth - 2] = res;
					eval_depth--;
				end
			end
		end
	endtask

	task automatic push_digit(input int d);
		logic [7:0] c;
		c = CH_ZERO + 8'(d);
		char_queue.push_back(c);
	endtask

	task automatic push_negative(input int k);
		push_digit(0);
		push_digit(k);
		char_queue.push_back(CH_MINUS);
	endtask

	function automatic logic [7:0] random_operator();
		logic [7:0] c;
		case ($urandom_range(0, 10))
			0, 1:    c = CH_PLUS;
			2, 3:    c = CH_MINUS;
			4, 5:    c = CH_STAR;
			6, 7:    c = CH_SLASH;
			8, 9:    c = CH_CARET;
			default: begin
				do begin
					c = 8'($urandom_range(1, 255));
				end while ((c >= CH_ZERO && c <= CH_NINE) || c == CH_PLUS ||
					c == CH_MINUS || c == CH_STAR || c == CH_SLASH || c == CH_CARET);
			end
		endcase
		return c;
	endfunction

	task automatic push_wellformed();
		int operands;
		int pushed;
		int depth;
		operands = $urandom_range(1, 9);
		pushed = 0;
		depth = 0;
		// leave an entry below the top now and then
		if ($urandom_range(0, 4) == 0)
			push_digit($urandom_range(0, 9));
		while (pushed < operands || depth > 1) begin
			if (pushed < operands && (depth < 2 || $urandom_range(0, 1) == 1)) begin
				push_digit($urandom_range(0, 9));
				pushed++;
				depth++;
			end else begin
				char_queue.push_back(random_operator());
				depth--;
			end
		end
		char_queue.push_back(CH_NUL);
	endtask

	task automatic push_min_int();
		push_digit(2);
		push_digit(3);
		push_digit(9);
		char_queue.push_back(CH_STAR);
		push_digit(4);
		char_queue.push_back(CH_PLUS);
		char_queue.push_back(CH_CARET);
	endtask

	// stimulus
	initial begin
		int kind;
		int n;
		int i;

		char_queue.push_back(CH_NUL);
		char_queue.push_back(CH_PLUS);
		push_digit(5);
		char_queue.push_back(CH_NUL);
		push_digit(5);
		push_digit(0);
		char_queue.push_back(CH_SLASH);
		char_queue.push_back(CH_NUL);
		push_digit(7);
		push_digit(3);
		char_queue.push_back(CH_MINUS);
		push_digit(9);
		char_queue.push_back(CH_STAR);
		push_digit(2);
		char_queue.push_back(CH_CARET);
		push_digit(4);
		char_queue.push_back(CH_SLASH);
		push_digit(1);
		char_queue.push_back(CH_PLUS);
		char_queue.push_back(CH_NUL);
		push_digit(3);
		push_digit(4);
		char_queue.push_back(8'hFF);
		char_queue.push_back(CH_NUL);
		push_digit(0);
		push_digit(0);
		char_queue.push_back(CH_CARET);
		char_queue.push_back(CH_NUL);

		while (char_queue.size() < 1040) begin
			kind = $urandom_range(0, 99);
			if (kind < 60) begin
				push_wellformed();
			end else if (kind < 68) begin
				n = $urandom_range(15, 19);
				for (i = 0; i < n; i++)
					push_digit($urandom_range(0, 9));
				if ($urandom_range(0, 1) == 1)
					char_queue.push_back(random_operator());
				char_queue.push_back(CH_NUL);
			end else if (kind < 74) begin
				push_min_int();
				case ($urandom_range(0, 2))
					0: begin
						push_negative(1);
						char_queue.push_back(CH_SLASH);
					end
					1: begin
						push_digit(1);
						char_queue.push_back(CH_MINUS);
					end
					default: ;
				endcase
				char_queue.push_back(CH_NUL);
			end else if (kind < 82) begin
				case ($urandom_range(0, 2))
					0:       push_digit(1);
					1:       push_negative(1);
					default: push_digit($urandom_range(0, 9));
				endcase
				if ($urandom_range(0, 4) == 0)
					push_digit(0);
				else
					push_negative($urandom_range(1, 9));
				char_queue.push_back(CH_CARET);
				char_queue.push_back(CH_NUL);
			end else if (kind < 88) begin
				if ($urandom_range(0, 1) == 1) begin
					char_queue.push_back(random_operator());
				end else begin
					push_digit($urandom_range(0, 9));
					push_digit(0);
					char_queue.push_back(CH_SLASH);
				end
				n = $urandom_range(1, 6);
				for (i = 0; i < n; i++)
					char_queue.push_back(8'($urandom_range(1, 255)));
				char_queue.push_back(CH_NUL);
			end else if (kind < 96) begin
				n = $urandom_range(1, 8);
				for (i = 0; i < n; i++)
					char_queue.push_back(8'($urandom_range(0, 255)));
				char_queue.push_back(CH_NUL);
			end else begin
				if ($urandom_range(0, 1) == 1)
					push_digit($urandom_range(0, 9));
				char_queue.push_back(CH_NUL);
			end
		end
		total_chars = char_queue.size();

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (accepted_chars != total_chars)
			@(posedge clk);
		while (outcomes.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);

		if (mismatches == 0 && outcomes.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#1_500_000;
		$display("TEST FAILED");
		$finish;
	end

	// sender: bursts with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			symbol_valid <= 1'b0;
			symbol <= CH_NUL;
			burst_left <= 0;
			gap_left <= 0;
		end else if (!symbol_valid || symbol_ready) begin
			if (gap_left != 0) begin
				symbol_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (char_queue.size() != 0) begin
				symbol <= char_queue.pop_front();
				symbol_valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 24);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				symbol_valid <= 1'b0;
			end
		end
	end

	// long hold-off on the result side, once
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && results_seen >= 30) begin
			hold_left <= LONG_HOLD;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// receiver stall pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
			rx_mode <= RX_OPEN;
			mode_left <= 0;
		end else begin
			if (mode_left == 0) begin
				rx_mode <= rx_mode_t'($urandom_range(0, 2));
				mode_left <= $urandom_range(8, 64);
			end else begin
				mode_left <= mode_left - 1;
			end
			if (hold_left != 0) begin
				result_ready <= 1'b0;
			end else begin
				case (rx_mode)
					RX_OPEN:   result_ready <= 1'b1;
					RX_CHOPPY: result_ready <= 1'($urandom_range(0, 1));
					default:   result_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// predict on accepted items, check emitted results
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accepted_chars <= 0;
			results_seen <= 0;
		end else begin
			if (symbol_valid && symbol_ready) begin
				evaluate_symbol(symbol);
				accepted_chars <= accepted_chars + 1;
			end
			if (result_valid && result_ready) begin
				results_seen <= results_seen + 1;
				if (outcomes.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected result: value=%0d status=%0d", value, status);
					mismatches++;
				end else begin
					head_outcome = outcomes.pop_front();
					if (value !== head_outcome.value || status !== head_outcome.status) begin
						if (mismatches < 10)
							$display("mismatch: value exp %0d got %0d, status exp %0d got %0d",
								$signed(head_outcome.value), value,
								head_outcome.status, status);
						mismatches++;
					end
				end
			end
		end
	end

endmodule
